/* hw/rtl/u16u8_pkg.sv */
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [15:0] CAPACITY_RESET = 16'd4096;

   localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE       = 21'h10000;
   localparam logic [20:0] LIMIT_ONE_BYTE  = 21'd128;
   localparam logic [20:0] LIMIT_TWO_BYTE  = 21'd2048;
   localparam logic [20:0] LIMIT_THREE_BYTE = 21'h10000;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_CUT    = 2'd1,
      STATUS_NO_LOW = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      status_type status;
      logic       string_done;
   } rsp_type;

   // One queued job: the bytes of one code point, or one error result.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      status_type      status;
      logic            closes;
   } job_type;

endpackage

/* hw/rtl/u16u8_front.sv */
// Front end: accepts code units, tracks surrogates and budget, builds byte jobs.
module u16u8_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  u16u8_pkg::req_type  req_data,
   output logic                push,
   output u16u8_pkg::job_type  push_job,
   input  logic                queue_full
);

   logic [15:0] cap_ff, cap_in;
   logic [15:0] left_ff, left_in;
   logic [9:0]  pend_high_ff, pend_high_in;
   logic        pend_valid_ff, pend_valid_in;
   logic        dropping_ff, dropping_in;
   logic        in_string_ff, in_string_in;

   logic        accept;
   logic        start;
   logic        eff_drop;
   logic        eff_pend;
   logic [15:0] eff_left;
   logic [15:0] unit;
   logic        last;
   logic        is_high;
   logic        is_low;
   logic [20:0] cp;
   logic [2:0]  n;
   logic [3:0][7:0] enc;
   logic        err;
   u16u8_pkg::status_type err_code;
   logic        emit;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign unit      = req_data.code_unit;
   assign last      = req_data.last_unit;
   assign start     = !in_string_ff;
   assign eff_drop  = start ? 1'b0 : dropping_ff;
   assign eff_pend  = start ? 1'b0 : pend_valid_ff;
   assign eff_left  = start ? cap_ff : left_ff;
   assign is_high   = (unit >= u16u8_pkg::HIGH_SURR_FIRST) && (unit <= u16u8_pkg::HIGH_SURR_LAST);
   assign is_low    = (unit >= u16u8_pkg::LOW_SURR_FIRST) && (unit <= u16u8_pkg::LOW_SURR_LAST);

   // code point: completed pair or the unit itself
   always_comb begin
      if (eff_pend) begin
         cp = u16u8_pkg::SUPP_BASE + {1'b0, pend_high_ff, unit[9:0]};
      end else begin
         cp = {5'd0, unit};
      end
   end

   always_comb begin
      enc = '0;
      priority if (cp < u16u8_pkg::LIMIT_ONE_BYTE) begin
         n = 3'd1;
         enc[0] = cp[7:0];
      end else if (cp < u16u8_pkg::LIMIT_TWO_BYTE) begin
         n = 3'd2;
         enc[0] = {3'b110, cp[10:6]};
         enc[1] = {2'b10, cp[5:0]};
      end else if (cp < u16u8_pkg::LIMIT_THREE_BYTE) begin
         n = 3'd3;
         enc[0] = {4'b1110, cp[15:12]};
         enc[1] = {2'b10, cp[11:6]};
         enc[2] = {2'b10, cp[5:0]};
      end else begin
         n = 3'd4;
         enc[0] = {5'b11110, cp[20:18]};
         enc[1] = {2'b10, cp[17:12]};
         enc[2] = {2'b10, cp[11:6]};
         enc[3] = {2'b10, cp[5:0]};
      end
   end

   always_comb begin
      pend_high_in  = pend_high_ff;
      pend_valid_in = pend_valid_ff;
      dropping_in   = dropping_ff;
      in_string_in  = in_string_ff;
      left_in       = left_ff;
      err           = 1'b0;
      err_code      = u16u8_pkg::STATUS_OK;
      emit          = 1'b0;
      if (accept) begin
         in_string_in  = 1'b1;
         dropping_in   = eff_drop;
         pend_valid_in = eff_pend;
         left_in       = eff_left;
         if (start) begin
            pend_high_in = '0;
         end
         priority if (eff_drop) begin
            if (last) begin
               dropping_in  = 1'b0;
               in_string_in = 1'b0;
            end
         end else if (eff_pend && !is_low) begin
            err      = 1'b1;
            err_code = u16u8_pkg::STATUS_NO_LOW;
         end else if (!eff_pend && is_high) begin
            if (last) begin
               err      = 1'b1;
               err_code = u16u8_pkg::STATUS_CUT;
            end else begin
               pend_high_in  = unit[9:0];
               pend_valid_in = 1'b1;
            end
         end else if (eff_left < {13'd0, n}) begin
            err      = 1'b1;
            err_code = u16u8_pkg::STATUS_FULL;
         end else begin
            emit          = 1'b1;
            left_in       = eff_left - {13'd0, n};
            pend_valid_in = 1'b0;
            pend_high_in  = '0;
            in_string_in  = !last;
         end
         if (err) begin
            pend_valid_in = 1'b0;
            pend_high_in  = '0;
            dropping_in   = !last;
            in_string_in  = !last;
         end
      end
   end

   assign push = err || emit;

   always_comb begin
      push_job.bytes    = err ? '0 : enc;
      push_job.last_idx = err ? 2'd0 : 2'(n - 3'd1);
      push_job.status   = err_code;
      push_job.closes   = err || last;
   end

   assign cap_in = csr_we ? csr_wdata : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= u16u8_pkg::CAPACITY_RESET;
         left_ff       <= u16u8_pkg::CAPACITY_RESET;
         pend_high_ff  <= '0;
         pend_valid_ff <= 1'b0;
         dropping_ff   <= 1'b0;
         in_string_ff  <= 1'b0;
      end else begin
         cap_ff        <= cap_in;
         left_ff       <= left_in;
         pend_high_ff  <= pend_high_in;
         pend_valid_ff <= pend_valid_in;
         dropping_ff   <= dropping_in;
         in_string_ff  <= in_string_in;
      end
   end

endmodule

/* hw/rtl/u16u8_queue.sv */
// Small job queue between the front end and the byte serializer.
module u16u8_queue #(
   parameter int unsigned Depth = u16u8_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u16u8_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output u16u8_pkg::job_type head_job
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   u16u8_pkg::job_type slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == CntFull);
   assign head_valid = (count_ff != '0);
   assign head_job   = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hw/rtl/u16u8_back.sv */
// Back end: sends the queued bytes one word per cycle through an output register, while the output is not stalled.
module u16u8_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  u16u8_pkg::job_type head_job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output u16u8_pkg::rsp_type rsp_data
);

   logic [1:0]         idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   u16u8_pkg::rsp_type rsp_ff, rsp_in;
   logic               load;
   logic               fin;

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign fin  = (idx_ff == head_job.last_idx);
   assign pop  = load && fin;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = head_job.bytes[idx_ff];
         rsp_in.run_last    = fin;
         rsp_in.status      = head_job.status;
         rsp_in.string_done = fin && head_job.closes;
         idx_in             = fin ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // byte index stays within the head job
   assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff <= head_job.last_idx))
      else $error("byte index past end of job");

   // an error result is a single zero word that closes the string
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != u16u8_pkg::STATUS_OK)) |->
      ((rsp_ff.out_byte == 8'd0) && rsp_ff.run_last && rsp_ff.string_done))
      else $error("malformed error result");

   // a job leaves the queue exactly when its final word is loaded
   assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid_ff && rsp_ff.run_last && (idx_ff == 2'd0)))
      else $error("job popped without final word");

endmodule

/* hw/rtl/utf16_to_utf8_transcoder.sv */
// Top level of the UTF-16 to UTF-8 transcoder.
// Converts a stream of UTF-16 code units (one per input word, last_unit marking
// the end of a string) into UTF-8 bytes, one byte per output word. A high
// surrogate is held until the next unit; a pair becomes four bytes, any other
// unit (lone low surrogates included) one to three. Each string gets a byte
// budget, loaded from the csr register when its first unit arrives; a code
// point that does not fit, a high surrogate at the end of a string, or a high
// surrogate not followed by a low one gives a single error word (byte zero,
// string_done set), and the rest of that string is dropped silently.
// Timing: the front end takes one unit per cycle whenever the job queue has
// room; the back end sends one byte per cycle while the output is not stalled,
// so throughput is set by the output port; units that give no output (a held
// high surrogate, dropped units) are absorbed by the front end alone. With an
// empty queue, an accepted unit's first byte passes through the queue slot,
// then the output register, before it is valid on the output. The csr
// register may only be written while the block is idle.
module utf16_to_utf8_transcoder #(
   parameter int unsigned QueueDepth = u16u8_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata,
   // code unit input
   input  logic               req_valid,
   output logic               req_ready,
   input  u16u8_pkg::req_type req_data,
   // byte output
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output u16u8_pkg::rsp_type rsp_data
);

   // front end -> queue
   logic               push;
   u16u8_pkg::job_type push_job;
   logic               queue_full;
   // queue -> back end
   logic               head_valid;
   u16u8_pkg::job_type head_job;
   logic               pop;

   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   // decouples classification from serialization
   u16u8_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
